// ===== hdl/als_pkg.sv =====
package als_pkg;

  // Token kinds.
  typedef logic [3:0] kind_t;
  localparam kind_t K_IDENT    = 4'd0;
  localparam kind_t K_INT      = 4'd1;
  localparam kind_t K_CHAR     = 4'd2;
  localparam kind_t K_STR_END  = 4'd3;
  localparam kind_t K_STR_BYTE = 4'd4;
  localparam kind_t K_COLON    = 4'd5;
  localparam kind_t K_COMMA    = 4'd6;
  localparam kind_t K_PLUS     = 4'd7;
  localparam kind_t K_MINUS    = 4'd8;
  localparam kind_t K_DOT      = 4'd9;
  localparam kind_t K_HASH     = 4'd10;
  localparam kind_t K_LBRACKET = 4'd11;
  localparam kind_t K_RBRACKET = 4'd12;
  localparam kind_t K_NEWLINE  = 4'd13;
  localparam kind_t K_EOF      = 4'd14;
  localparam kind_t K_ERROR    = 4'd15;

  // Error codes.
  typedef logic [3:0] err_t;
  localparam err_t E_NONE       = 4'd0;
  localparam err_t E_UNEXPECTED = 4'd1;
  localparam err_t E_MALFORMED  = 4'd2;
  localparam err_t E_BAD_DIGIT  = 4'd3;
  localparam err_t E_TOO_BIG    = 4'd4;
  localparam err_t E_ESC_END    = 4'd5;
  localparam err_t E_NO_HEX     = 4'd6;
  localparam err_t E_BAD_ESC    = 4'd7;
  localparam err_t E_STR_OPEN   = 4'd8;
  localparam err_t E_CHR_OPEN   = 4'd9;
  localparam err_t E_CHR_EMPTY  = 4'd10;

  // Source characters.
  localparam logic [7:0] C_NL     = 8'h0A;
  localparam logic [7:0] C_TAB    = 8'h09;
  localparam logic [7:0] C_VT     = 8'h0B;
  localparam logic [7:0] C_FF     = 8'h0C;
  localparam logic [7:0] C_CR     = 8'h0D;
  localparam logic [7:0] C_SP     = 8'h20;
  localparam logic [7:0] C_DQUOTE = 8'h22;
  localparam logic [7:0] C_HASH   = 8'h23;
  localparam logic [7:0] C_SQUOTE = 8'h27;
  localparam logic [7:0] C_PLUS   = 8'h2B;
  localparam logic [7:0] C_COMMA  = 8'h2C;
  localparam logic [7:0] C_MINUS  = 8'h2D;
  localparam logic [7:0] C_DOT    = 8'h2E;
  localparam logic [7:0] C_ZERO   = 8'h30;
  localparam logic [7:0] C_NINE   = 8'h39;
  localparam logic [7:0] C_COLON  = 8'h3A;
  localparam logic [7:0] C_SEMI   = 8'h3B;
  localparam logic [7:0] C_UA     = 8'h41;
  localparam logic [7:0] C_UZ     = 8'h5A;
  localparam logic [7:0] C_LBRK   = 8'h5B;
  localparam logic [7:0] C_BSLASH = 8'h5C;
  localparam logic [7:0] C_RBRK   = 8'h5D;
  localparam logic [7:0] C_USCORE = 8'h5F;
  localparam logic [7:0] C_LA     = 8'h61;
  localparam logic [7:0] C_LB     = 8'h62;
  localparam logic [7:0] C_LF     = 8'h66;
  localparam logic [7:0] C_LN     = 8'h6E;
  localparam logic [7:0] C_LO     = 8'h6F;
  localparam logic [7:0] C_LR     = 8'h72;
  localparam logic [7:0] C_LT     = 8'h74;
  localparam logic [7:0] C_LX     = 8'h78;
  localparam logic [7:0] C_LZ     = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  localparam logic [4:0] BASE_DEC  = 5'd10;
  localparam logic [4:0] NOT_DIGIT = 5'd16;

  typedef enum logic [1:0] {
    SEL_DEC = 2'd0,
    SEL_HEX = 2'd1,
    SEL_BIN = 2'd2,
    SEL_OCT = 2'd3
  } base_sel_t;

  typedef enum logic [13:0] {
    M_IDLE      = 14'b00000000000001,
    M_COMMENT   = 14'b00000000000010,
    M_MINUS     = 14'b00000000000100,
    M_ZERO      = 14'b00000000001000,
    M_DIGITS    = 14'b00000000010000,
    M_INT_SKIP  = 14'b00000000100000,
    M_IDENT     = 14'b00000001000000,
    M_STR       = 14'b00000010000000,
    M_STR_ESC   = 14'b00000100000000,
    M_STR_HEX   = 14'b00001000000000,
    M_CHR_OPEN  = 14'b00010000000000,
    M_CHR_ESC   = 14'b00100000000000,
    M_CHR_HEX   = 14'b01000000000000,
    M_CHR_CLOSE = 14'b10000000000000
  } lex_mode_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= C_ZERO) && (c <= C_NINE);
  endfunction

  function automatic logic ident_start(logic [7:0] c);
    return ((c >= C_LA) && (c <= C_LZ)) || ((c >= C_UA) && (c <= C_UZ)) || (c == C_USCORE);
  endfunction

  function automatic logic ident_cont(logic [7:0] c);
    return ident_start(c) || is_digit(c);
  endfunction

  function automatic logic [7:0] lower_c(logic [7:0] c);
    return ((c >= C_UA) && (c <= C_UZ)) ? (c + CASE_GAP) : c;
  endfunction

  // Digit value, or NOT_DIGIT when the byte is no hex digit.
  function automatic logic [4:0] digit_val(logic [7:0] c);
    logic [7:0] lc;
    logic [7:0] t;
    lc = lower_c(c);
    if (is_digit(lc)) begin
      t = lc - C_ZERO;
      return {1'b0, t[3:0]};
    end
    if ((lc >= C_LA) && (lc <= C_LF)) begin
      t = lc - C_LA + 8'd10;
      return {1'b0, t[3:0]};
    end
    return NOT_DIGIT;
  endfunction

  function automatic logic [4:0] base_of(base_sel_t sel);
    logic [4:0] b;
    unique case (sel)
      SEL_HEX: b = 5'd16;
      SEL_BIN: b = 5'd2;
      SEL_OCT: b = 5'd8;
      default: b = BASE_DEC;
    endcase
    return b;
  endfunction

  // Simple escapes: bit 8 says the escape is known, bits 7:0 hold its byte.
  function automatic logic [8:0] escape_val(logic [7:0] c);
    logic [8:0] r;
    case (c)
      C_LN:     r = {1'b1, C_NL};
      C_LT:     r = {1'b1, C_TAB};
      C_LR:     r = {1'b1, C_CR};
      C_ZERO:   r = 9'h100;
      C_BSLASH: r = {1'b1, C_BSLASH};
      C_SQUOTE: r = {1'b1, C_SQUOTE};
      C_DQUOTE: r = {1'b1, C_DQUOTE};
      default:  r = 9'h000;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/als_byte_if.sv =====
interface als_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink (input valid, input ch, input end_of_input, output ready);
endinterface

// ===== hdl/als_token_if.sv =====
interface als_token_if #(
  parameter int POS_W = 32
);
  logic              valid;
  logic              ready;
  logic [3:0]        kind;
  logic signed [63:0] value;
  logic [3:0]        error_code;
  logic [4:0]        digit_base;
  logic [POS_W-1:0]  line;
  logic [POS_W-1:0]  column;
  logic [POS_W-1:0]  length;
  logic              last;

  modport source (output valid, output kind, output value, output error_code,
                  output digit_base, output line, output column, output length,
                  output last, input ready);
  modport sink (input valid, input kind, input value, input error_code,
                input digit_base, input line, input column, input length,
                input last, output ready);
endinterface

// ===== hdl/assembly_lexer_stream.sv =====
// Streaming assembly lexer: one source byte (or an end-of-input mark) per word on
// the bytes channel, tokens on the tokens channel. Each byte is lexed in the cycle
// it is accepted, by up to three passes of combinational logic over the lexer
// state, and the up to three tokens it completes go into a four-deep token queue.
// A byte is taken every cycle while the queue holds at most one token, so the
// sustained rate is one byte per cycle when bytes yield one token or less and the
// token sink does not stall; a byte that yields more tokens holds the input back
// until the queue drains. Line, column and length count modulo 2^POSITION_WIDTH.
module assembly_lexer_stream #(
  parameter int POSITION_WIDTH = 32
) (
  input logic clk,
  input logic rst,
  als_byte_if.sink bytes,
  als_token_if.source tokens
);
  import als_pkg::*;

  localparam int PW = POSITION_WIDTH;
  localparam int QD = 4;

  typedef struct packed {
    lex_mode_t   mode;
    logic [63:0] mag;
    logic        ovf;
    logic        neg;
    base_sel_t   sel;
    logic        seen;
    logic [7:0]  hacc;
    logic [1:0]  hcnt;
    logic [7:0]  chv;
    err_t        pend;
    logic [PW-1:0] line;
    logic [PW-1:0] col;
    logic [PW-1:0] tcol;
    logic [PW-1:0] tlen;
  } lex_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] value;
    err_t        err;
    logic [4:0]  base;
    logic [PW-1:0] line;
    logic [PW-1:0] col;
    logic [PW-1:0] len;
    logic        last;
  } token_t;

  typedef struct packed {
    lex_state_t st;
    logic       done;
    logic       emit;
    token_t     tok;
  } pass_t;

  lex_state_t state, state_next;
  token_t     queue [QD];
  token_t     queue_next [QD];
  logic [2:0] count, count_next;

  function automatic token_t mk(lex_state_t s, kind_t k, logic [63:0] v, err_t e,
                                logic [4:0] b);
    token_t t;
    t.kind  = k;
    t.value = v;
    t.err   = e;
    t.base  = b;
    t.line  = s.line;
    t.col   = s.tcol;
    t.len   = s.tlen;
    t.last  = 1'b0;
    return t;
  endfunction

  function automatic lex_state_t take(lex_state_t s);
    lex_state_t r;
    r = s;
    r.tlen = s.tlen + 1'b1;
    r.col  = s.col + 1'b1;
    return r;
  endfunction

  // Magnitude times a constant base; the top four bits flag a 64-bit overflow.
  function automatic logic [67:0] mul_base(logic [63:0] m, base_sel_t sel);
    logic [67:0] r;
    unique case (sel)
      SEL_HEX: r = {m, 4'b0};
      SEL_BIN: r = {3'b0, m, 1'b0};
      SEL_OCT: r = {1'b0, m, 3'b0};
      default: r = {1'b0, m, 3'b0} + {3'b0, m, 1'b0};
    endcase
    return r;
  endfunction

  function automatic lex_state_t start_number(lex_state_t s, logic [7:0] c);
    lex_state_t r;
    logic [7:0] dv;
    r = take(s);
    dv = c - C_ZERO;
    r.sel = SEL_DEC;
    r.ovf = 1'b0;
    r.mag = '0;
    if (c == C_ZERO) begin
      r.seen = 1'b0;
      r.mode = M_ZERO;
    end else begin
      r.mag  = {60'b0, dv[3:0]};
      r.seen = 1'b1;
      r.mode = M_DIGITS;
    end
    return r;
  endfunction

  // Between tokens: skip blanks and comments, emit single-byte, error and end tokens, or open a new token.
  function automatic pass_t idle_pass(lex_state_t s_in, logic [7:0] c, logic eoi);
    pass_t p;
    lex_state_t s;
    s = s_in;
    s.mode = M_IDLE;
    s.tcol = s.col;
    s.tlen = '0;
    p.done = 1'b1;
    p.emit = 1'b0;
    p.tok  = mk(s, K_EOF, 64'd0, E_NONE, BASE_DEC);
    if (eoi) begin
      p.emit = 1'b1;
      s.line = PW'(1);
      s.col  = PW'(1);
    end else begin
      s.neg = 1'b0;
      case (c) inside
        C_SP, C_TAB, C_CR, C_FF, C_VT: begin
          s.col = s.col + 1'b1;
        end
        C_SEMI: begin
          s.col  = s.col + 1'b1;
          s.mode = M_COMMENT;
        end
        C_COLON, C_COMMA, C_PLUS, C_DOT, C_HASH, C_LBRK, C_RBRK, C_NL: begin
          s = take(s);
          p.emit = 1'b1;
          case (c)
            C_COLON: p.tok = mk(s, K_COLON, 64'd0, E_NONE, BASE_DEC);
            C_COMMA: p.tok = mk(s, K_COMMA, 64'd0, E_NONE, BASE_DEC);
            C_PLUS:  p.tok = mk(s, K_PLUS, 64'd0, E_NONE, BASE_DEC);
            C_DOT:   p.tok = mk(s, K_DOT, 64'd0, E_NONE, BASE_DEC);
            C_HASH:  p.tok = mk(s, K_HASH, 64'd0, E_NONE, BASE_DEC);
            C_LBRK:  p.tok = mk(s, K_LBRACKET, 64'd0, E_NONE, BASE_DEC);
            C_RBRK:  p.tok = mk(s, K_RBRACKET, 64'd0, E_NONE, BASE_DEC);
            default: p.tok = mk(s, K_NEWLINE, 64'd0, E_NONE, BASE_DEC);
          endcase
          if (c == C_NL) begin
            s.line = s.line + 1'b1;
            s.col  = PW'(1);
          end
        end
        C_MINUS: begin
          s = take(s);
          s.mode = M_MINUS;
        end
        C_DQUOTE: begin
          s = take(s);
          s.mode = M_STR;
        end
        C_SQUOTE: begin
          s = take(s);
          s.mode = M_CHR_OPEN;
        end
        default: begin
          if (ident_start(c)) begin
            s = take(s);
            s.mode = M_IDENT;
          end else if (is_digit(c)) begin
            s = start_number(s, c);
          end else begin
            s = take(s);
            p.emit = 1'b1;
            p.tok  = mk(s, K_ERROR, 64'd0, E_UNEXPECTED, BASE_DEC);
          end
        end
      endcase
    end
    p.st = s;
    return p;
  endfunction

  // One pass over the current mode; done low means the byte is offered again.
  function automatic pass_t lex_pass(lex_state_t s_in, logic [7:0] c, logic eoi);
    pass_t p;
    lex_state_t s;
    logic [7:0] lc;
    logic [4:0] d;
    logic [4:0] b;
    logic [67:0] acc;
    logic [8:0] esc;
    logic [63:0] lim;
    logic [7:0] tv;
    s = s_in;
    lc  = lower_c(c);
    d   = digit_val(c);
    b   = base_of(s.sel);
    acc = mul_base(s.mag, s.sel) + {63'b0, d};
    esc = escape_val(c);
    lim = s.neg ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    p.done = 1'b1;
    p.emit = 1'b0;
    p.tok  = mk(s, K_ERROR, 64'd0, E_NONE, BASE_DEC);
    p.st   = s;
    unique case (s.mode)
      M_COMMENT: begin
        if (eoi || (c == C_NL)) begin
          s.mode = M_IDLE;
          p.done = 1'b0;
        end else begin
          s.col = s.col + 1'b1;
        end
        p.st = s;
      end
      M_MINUS: begin
        if (!eoi && is_digit(c)) begin
          s.neg = 1'b1;
          s = start_number(s, c);
        end else begin
          p.emit = 1'b1;
          p.tok  = mk(s, K_MINUS, 64'd0, E_NONE, BASE_DEC);
          s.mode = M_IDLE;
          p.done = 1'b0;
        end
        p.st = s;
      end
      M_ZERO: begin
        if (!eoi && ((lc == C_LX) || (lc == C_LB) || (lc == C_LO))) begin
          s.sel  = (lc == C_LX) ? SEL_HEX : ((lc == C_LB) ? SEL_BIN : SEL_OCT);
          s.seen = 1'b0;
          s = take(s);
        end else begin
          s.sel  = SEL_DEC;
          s.seen = 1'b1;
          s.mag  = '0;
          p.done = 1'b0;
        end
        s.mode = M_DIGITS;
        p.st = s;
      end
      M_DIGITS: begin
        if (!eoi && (d < b)) begin
          if (acc[67:64] != 4'd0) begin
            s.ovf = 1'b1;
          end
          s.mag  = acc[63:0];
          s.seen = 1'b1;
          s = take(s);
        end else if (!eoi && ident_cont(c)) begin
          s.pend = s.seen ? E_BAD_DIGIT : E_MALFORMED;
          s = take(s);
          s.mode = M_INT_SKIP;
        end else begin
          p.emit = 1'b1;
          if (!s.seen) begin
            p.tok = mk(s, K_ERROR, 64'd0, E_MALFORMED, BASE_DEC);
          end else if (s.ovf || (s.mag > lim)) begin
            p.tok = mk(s, K_ERROR, 64'd0, E_TOO_BIG, BASE_DEC);
          end else begin
            p.tok = mk(s, K_INT, s.neg ? (64'd0 - s.mag) : s.mag, E_NONE, b);
          end
          s.mode = M_IDLE;
          p.done = 1'b0;
        end
        p.st = s;
      end
      M_INT_SKIP: begin
        if (!eoi && ident_cont(c)) begin
          s = take(s);
        end else begin
          p.emit = 1'b1;
          p.tok  = mk(s, K_ERROR, 64'd0, s.pend, (s.pend == E_BAD_DIGIT) ? b : BASE_DEC);
          s.mode = M_IDLE;
          p.done = 1'b0;
        end
        p.st = s;
      end
      M_IDENT: begin
        if (!eoi && ident_cont(c)) begin
          s = take(s);
        end else begin
          p.emit = 1'b1;
          p.tok  = mk(s, K_IDENT, 64'd0, E_NONE, BASE_DEC);
          s.mode = M_IDLE;
          p.done = 1'b0;
        end
        p.st = s;
      end
      M_STR: begin
        if (eoi || (c == C_NL)) begin
          p.emit = 1'b1;
          p.tok  = mk(s, K_ERROR, 64'd0, E_STR_OPEN, BASE_DEC);
          s.mode = M_IDLE;
          p.done = 1'b0;
        end else begin
          s = take(s);
          if (c == C_DQUOTE) begin
            p.emit = 1'b1;
            p.tok  = mk(s, K_STR_END, 64'd0, E_NONE, BASE_DEC);
            s.mode = M_IDLE;
          end else if (c == C_BSLASH) begin
            s.mode = M_STR_ESC;
          end else begin
            p.emit = 1'b1;
            p.tok  = mk(s, K_STR_BYTE, {56'b0, c}, E_NONE, BASE_DEC);
          end
        end
        p.st = s;
      end
      M_STR_ESC, M_CHR_ESC: begin
        if (eoi) begin
          p.emit = 1'b1;
          p.tok  = mk(s, K_ERROR, 64'd0, E_ESC_END, BASE_DEC);
          s.mode = M_IDLE;
          p.done = 1'b0;
        end else begin
          s = take(s);
          if (esc[8]) begin
            if (s.mode == M_STR_ESC) begin
              p.emit = 1'b1;
              p.tok  = mk(s, K_STR_BYTE, {56'b0, esc[7:0]}, E_NONE, BASE_DEC);
              s.mode = M_STR;
            end else begin
              s.chv  = esc[7:0];
              s.mode = M_CHR_CLOSE;
            end
          end else if (c == C_LX) begin
            s.hacc = '0;
            s.hcnt = '0;
            s.mode = (s.mode == M_STR_ESC) ? M_STR_HEX : M_CHR_HEX;
          end else begin
            p.emit = 1'b1;
            p.tok  = mk(s, K_ERROR, 64'd0, E_BAD_ESC, BASE_DEC);
            s.mode = M_IDLE;
          end
        end
        p.st = s;
      end
      M_STR_HEX, M_CHR_HEX: begin
        if (!eoi && (d < NOT_DIGIT)) begin
          s = take(s);
          s.hacc = {s.hacc[3:0], d[3:0]};
          s.hcnt = s.hcnt + 1'b1;
        end
        if (!eoi && (d < NOT_DIGIT) && (s.hcnt < 2'd2)) begin
          p.done = 1'b1;
        end else if (!(!eoi && (d < NOT_DIGIT)) && (s.hcnt == 2'd0)) begin
          p.emit = 1'b1;
          p.tok  = mk(s, K_ERROR, 64'd0, E_NO_HEX, BASE_DEC);
          s.mode = M_IDLE;
          p.done = 1'b0;
        end else begin
          if (s.mode == M_STR_HEX) begin
            p.emit = 1'b1;
            p.tok  = mk(s, K_STR_BYTE, {56'b0, s.hacc}, E_NONE, BASE_DEC);
            s.mode = M_STR;
          end else begin
            s.chv  = s.hacc;
            s.mode = M_CHR_CLOSE;
          end
          p.done = !eoi && (d < NOT_DIGIT);
        end
        p.st = s;
      end
      M_CHR_OPEN: begin
        if (eoi || (c == C_NL)) begin
          p.emit = 1'b1;
          p.tok  = mk(s, K_ERROR, 64'd0, E_CHR_OPEN, BASE_DEC);
          s.mode = M_IDLE;
          p.done = 1'b0;
        end else begin
          s = take(s);
          if (c == C_BSLASH) begin
            s.mode = M_CHR_ESC;
          end else if (c == C_SQUOTE) begin
            p.emit = 1'b1;
            p.tok  = mk(s, K_ERROR, 64'd0, E_CHR_EMPTY, BASE_DEC);
            s.mode = M_IDLE;
          end else begin
            s.chv  = c;
            s.mode = M_CHR_CLOSE;
          end
        end
        p.st = s;
      end
      M_CHR_CLOSE: begin
        if (!eoi && (c == C_SQUOTE)) begin
          s = take(s);
          tv = s.chv;
          p.emit = 1'b1;
          p.tok  = mk(s, K_CHAR, {56'b0, tv}, E_NONE, BASE_DEC);
        end else begin
          p.emit = 1'b1;
          p.tok  = mk(s, K_ERROR, 64'd0, E_CHR_OPEN, BASE_DEC);
          p.done = 1'b0;
        end
        s.mode = M_IDLE;
        p.st = s;
      end
      default: begin
        p = idle_pass(s, c, eoi);
      end
    endcase
    return p;
  endfunction

  // Lexing: at most three passes over one byte, then compaction of the tokens.
  pass_t p1, p2, p3;
  logic       v1, v2, v3;
  logic [1:0] nres;
  token_t     new_tok [3];
  logic       accept, pop;
  logic [2:0] after_pop;

  always_comb begin
    p1 = lex_pass(state, bytes.ch, bytes.end_of_input);
    p2 = lex_pass(p1.st, bytes.ch, bytes.end_of_input);
    p3 = lex_pass(p2.st, bytes.ch, bytes.end_of_input);
    v1 = p1.emit;
    v2 = !p1.done && p2.emit;
    v3 = !p1.done && !p2.done && p3.emit;
    nres = 2'(v1) + 2'(v2) + 2'(v3);
    if (p1.done) begin
      state_next = p1.st;
    end else if (p2.done) begin
      state_next = p2.st;
    end else begin
      state_next = p3.st;
    end
    new_tok[0] = v1 ? p1.tok : (v2 ? p2.tok : p3.tok);
    new_tok[1] = (v1 && v2) ? p2.tok : p3.tok;
    new_tok[2] = p3.tok;
    new_tok[0].last = (nres == 2'd1);
    new_tok[1].last = (nres == 2'd2);
    new_tok[2].last = 1'b1;
  end

  // Token queue: entry 0 is the output word; pops shift the queue down.
  assign accept    = bytes.valid && bytes.ready;
  assign pop       = tokens.valid && tokens.ready;
  assign after_pop = count - 3'(pop);

  always_comb begin
    logic [2:0] idx;
    for (int i = 0; i < QD; i++) begin
      if (pop && (i < QD - 1)) begin
        queue_next[i] = queue[i + 1];
      end else begin
        queue_next[i] = queue[i];
      end
      idx = 3'(i) - after_pop;
      if (accept && (3'(i) >= after_pop) && (idx < 3'(nres))) begin
        queue_next[i] = new_tok[idx[1:0]];
      end
    end
    count_next = after_pop + (accept ? 3'(nres) : 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode <= M_IDLE;
      state.mag  <= '0;
      state.ovf  <= 1'b0;
      state.neg  <= 1'b0;
      state.sel  <= SEL_DEC;
      state.seen <= 1'b0;
      state.hacc <= '0;
      state.hcnt <= '0;
      state.chv  <= '0;
      state.pend <= E_NONE;
      state.line <= PW'(1);
      state.col  <= PW'(1);
      state.tcol <= '0;
      state.tlen <= '0;
      count      <= '0;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    queue <= queue_next;
  end

  // Channel outputs.
  assign bytes.ready       = (count <= 3'd1);
  assign tokens.valid      = (count != 3'd0);
  assign tokens.kind       = queue[0].kind;
  assign tokens.value      = queue[0].value;
  assign tokens.error_code = queue[0].err;
  assign tokens.digit_base = queue[0].base;
  assign tokens.line       = queue[0].line;
  assign tokens.column     = queue[0].col;
  assign tokens.length     = queue[0].len;
  assign tokens.last       = queue[0].last;

endmodule

// ===== hdl/als_checker.sv =====
module als_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_end,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_kind,
  input logic       out_last,
  input logic [63:0] out_value
);
  import als_pkg::*;

  // Nothing is offered straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("token offered after reset");

  // Input back-pressure only comes from tokens waiting at the output.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no token waiting");

  // An end-of-input word always yields at least its end token.
  a_eof_yields: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_end) |=> out_valid)
    else $error("end of input gave no token");

  // The end token closes the tokens of its word.
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == K_EOF)) |-> out_last)
    else $error("end token not marked last");

  // A stalled token holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_kind) && $stable(out_value)))
    else $error("stalled token changed");

endmodule

bind assembly_lexer_stream als_checker u_als_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (bytes.valid),
  .in_ready  (bytes.ready),
  .in_end    (bytes.end_of_input),
  .out_valid (tokens.valid),
  .out_ready (tokens.ready),
  .out_kind  (tokens.kind),
  .out_last  (tokens.last),
  .out_value (tokens.value)
);

// ===== tb/assembly_lexer_stream_test.sv =====
module assembly_lexer_stream_test;
  timeunit 1ns;
  timeprecision 1ps;

  import als_pkg::*;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic [3:0]  err;
    logic [4:0]  base;
    logic [31:0] line;
    logic [31:0] column;
    logic [31:0] length;
    logic        last;
  } token_t;

  typedef struct packed {
    logic       fin;
    logic [7:0] ch;
  } src_word_t;

  logic clk;
  logic rst;

  als_byte_if byte_if();
  als_token_if #(.POS_W(32)) tok_if();

  assembly_lexer_stream #(.POSITION_WIDTH(32)) uut (
    .clk(clk),
    .rst(rst),
    .bytes(byte_if),
    .tokens(tok_if)
  );

  src_word_t source_words[$];
  token_t    expected_tokens[$];
  token_t    step_tokens[$];
  int        fail_count = 0;

  // Predicted lexer state.
  lex_mode_t   p_mode;
  logic [63:0] p_mag;
  logic        p_ovf;
  logic        p_neg;
  base_sel_t   p_bsel;
  logic        p_dseen;
  logic [7:0]  p_hacc;
  logic [1:0]  p_hcnt;
  logic [7:0]  p_cval;
  err_t        p_perr;
  logic [31:0] p_line;
  logic [31:0] p_col;
  logic [31:0] p_tcol;
  logic [31:0] p_tlen;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic is_num(logic [7:0] c);
    return c >= C_ZERO && c <= C_NINE;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= C_LA && c <= C_LZ) || (c >= C_UA && c <= C_UZ) || c == C_USCORE;
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= C_UA && c <= C_UZ) ? c + CASE_GAP : c;
  endfunction

  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [7:0] l;
    l = fold_case(c);
    if (is_num(l)) return 5'(l - C_ZERO);
    if (l >= C_LA && l <= C_LF) return 5'(l - C_LA + 8'd10);
    return NOT_DIGIT;
  endfunction

  function automatic logic [4:0] radix(base_sel_t s);
    case (s)
      SEL_HEX: return 5'd16;
      SEL_BIN: return 5'd2;
      SEL_OCT: return 5'd8;
      default: return BASE_DEC;
    endcase
  endfunction

  function automatic logic decode_escape(logic [7:0] c, output logic [7:0] v);
    v = 8'd0;
    case (c)
      C_LN: v = C_NL;
      C_LT: v = C_TAB;
      C_LR: v = C_CR;
      C_ZERO: v = 8'd0;
      C_BSLASH, C_SQUOTE, C_DQUOTE: v = c;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void lexer_clear();
    p_mode = M_IDLE;
    p_mag = '0;
    p_ovf = 1'b0;
    p_neg = 1'b0;
    p_bsel = SEL_DEC;
    p_dseen = 1'b0;
    p_hacc = '0;
    p_hcnt = '0;
    p_cval = '0;
    p_perr = E_NONE;
    p_line = 32'd1;
    p_col = 32'd1;
    p_tcol = '0;
    p_tlen = '0;
  endfunction

  function automatic void add_token(logic [3:0] k, logic [63:0] v, err_t e, logic [4:0] b);
    token_t t;
    if (step_tokens.size() >= 3) return;
    t = '{kind: k, value: v, err: e, base: b, line: p_line, column: p_tcol,
          length: p_tlen, last: 1'b0};
    step_tokens = {step_tokens, t};
  endfunction

  function automatic void add_error(err_t e);
    add_token(K_ERROR, '0, e, BASE_DEC);
    p_mode = M_IDLE;
  endfunction

  function automatic void advance();
    p_tlen++;
    p_col++;
  endfunction

  function automatic void begin_number(logic [7:0] c);
    p_bsel = SEL_DEC;
    p_ovf = 1'b0;
    p_mag = '0;
    advance();
    if (c == C_ZERO) begin
      p_dseen = 1'b0;
      p_mode = M_ZERO;
    end else begin
      p_mag = 64'(c - C_ZERO);
      p_dseen = 1'b1;
      p_mode = M_DIGITS;
    end
  endfunction

  function automatic void close_integer();
    logic [63:0] bound;
    bound = 64'h8000_0000_0000_0000;
    if (!p_neg) bound = bound - 1;
    if (p_ovf || p_mag > bound) begin
      add_error(E_TOO_BIG);
      return;
    end
    add_token(K_INT, p_neg ? 64'd0 - p_mag : p_mag, E_NONE, radix(p_bsel));
    p_mode = M_IDLE;
  endfunction

  function automatic void lex_idle(logic [7:0] c, logic fin);
    p_tcol = p_col;
    p_tlen = '0;
    if (fin) begin
      add_token(K_EOF, '0, E_NONE, BASE_DEC);
      p_line = 32'd1;
      p_col = 32'd1;
      return;
    end
    p_neg = 1'b0;
    case (c)
      C_SP, C_TAB, C_CR, C_FF, C_VT: p_col++;
      C_SEMI: begin
        p_col++;
        p_mode = M_COMMENT;
      end
      C_COLON: begin advance(); add_token(K_COLON, '0, E_NONE, BASE_DEC); end
      C_COMMA: begin advance(); add_token(K_COMMA, '0, E_NONE, BASE_DEC); end
      C_PLUS: begin advance(); add_token(K_PLUS, '0, E_NONE, BASE_DEC); end
      C_DOT: begin advance(); add_token(K_DOT, '0, E_NONE, BASE_DEC); end
      C_HASH: begin advance(); add_token(K_HASH, '0, E_NONE, BASE_DEC); end
      C_LBRK: begin advance(); add_token(K_LBRACKET, '0, E_NONE, BASE_DEC); end
      C_RBRK: begin advance(); add_token(K_RBRACKET, '0, E_NONE, BASE_DEC); end
      C_NL: begin
        advance();
        add_token(K_NEWLINE, '0, E_NONE, BASE_DEC);
        p_line++;
        p_col = 32'd1;
      end
      C_MINUS: begin advance(); p_mode = M_MINUS; end
      C_DQUOTE: begin advance(); p_mode = M_STR; end
      C_SQUOTE: begin advance(); p_mode = M_CHR_OPEN; end
      default: begin
        if (is_alpha(c)) begin
          advance();
          p_mode = M_IDENT;
        end else if (is_num(c)) begin
          begin_number(c);
        end else begin
          advance();
          add_error(E_UNEXPECTED);
        end
      end
    endcase
  endfunction

  // One pass over the byte; a zero return means the byte is offered again.
  function automatic logic lex_pass(logic [7:0] c, logic fin);
    logic [7:0] v;
    logic [4:0] b;
    logic [4:0] d;
    case (p_mode)
      M_COMMENT: begin
        if (fin || c == C_NL) begin
          p_mode = M_IDLE;
          return 1'b0;
        end
        p_col++;
        return 1'b1;
      end
      M_MINUS: begin
        if (!fin && is_num(c)) begin
          p_neg = 1'b1;
          begin_number(c);
          return 1'b1;
        end
        add_token(K_MINUS, '0, E_NONE, BASE_DEC);
        p_mode = M_IDLE;
        return 1'b0;
      end
      M_ZERO: begin
        v = fold_case(c);
        if (!fin && (v == C_LX || v == C_LB || v == C_LO)) begin
          p_bsel = (v == C_LX) ? SEL_HEX : (v == C_LB) ? SEL_BIN : SEL_OCT;
          p_dseen = 1'b0;
          advance();
          p_mode = M_DIGITS;
          return 1'b1;
        end
        p_bsel = SEL_DEC;
        p_dseen = 1'b1;
        p_mag = '0;
        p_mode = M_DIGITS;
        return 1'b0;
      end
      M_DIGITS: begin
        b = radix(p_bsel);
        d = hex_value(c);
        if (!fin && d < b) begin
          if (p_mag > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'(b)) p_ovf = 1'b1;
          p_mag = p_mag * 64'(b) + 64'(d);
          p_dseen = 1'b1;
          advance();
          return 1'b1;
        end
        if (!fin && (is_alpha(c) || is_num(c))) begin
          p_perr = p_dseen ? E_BAD_DIGIT : E_MALFORMED;
          advance();
          p_mode = M_INT_SKIP;
          return 1'b1;
        end
        if (!p_dseen) add_error(E_MALFORMED);
        else close_integer();
        return 1'b0;
      end
      M_INT_SKIP: begin
        if (!fin && (is_alpha(c) || is_num(c))) begin
          advance();
          return 1'b1;
        end
        add_token(K_ERROR, '0, p_perr, (p_perr == E_BAD_DIGIT) ? radix(p_bsel) : BASE_DEC);
        p_mode = M_IDLE;
        return 1'b0;
      end
      M_IDENT: begin
        if (!fin && (is_alpha(c) || is_num(c))) begin
          advance();
          return 1'b1;
        end
        add_token(K_IDENT, '0, E_NONE, BASE_DEC);
        p_mode = M_IDLE;
        return 1'b0;
      end
      M_STR: begin
        if (fin || c == C_NL) begin
          add_error(E_STR_OPEN);
          return 1'b0;
        end
        advance();
        if (c == C_DQUOTE) begin
          add_token(K_STR_END, '0, E_NONE, BASE_DEC);
          p_mode = M_IDLE;
        end else if (c == C_BSLASH) begin
          p_mode = M_STR_ESC;
        end else begin
          add_token(K_STR_BYTE, 64'(c), E_NONE, BASE_DEC);
        end
        return 1'b1;
      end
      M_STR_ESC, M_CHR_ESC: begin
        if (fin) begin
          add_error(E_ESC_END);
          return 1'b0;
        end
        advance();
        if (decode_escape(c, v)) begin
          if (p_mode == M_STR_ESC) begin
            add_token(K_STR_BYTE, 64'(v), E_NONE, BASE_DEC);
            p_mode = M_STR;
          end else begin
            p_cval = v;
            p_mode = M_CHR_CLOSE;
          end
        end else if (c == C_LX) begin
          p_hacc = '0;
          p_hcnt = '0;
          p_mode = (p_mode == M_STR_ESC) ? M_STR_HEX : M_CHR_HEX;
        end else begin
          add_error(E_BAD_ESC);
        end
        return 1'b1;
      end
      M_STR_HEX, M_CHR_HEX: begin
        d = hex_value(c);
        if (!fin && d < NOT_DIGIT) begin
          advance();
          p_hacc = {p_hacc[3:0], d[3:0]};
          p_hcnt++;
          if (p_hcnt < 2) return 1'b1;
        end else if (p_hcnt == 0) begin
          add_error(E_NO_HEX);
          return 1'b0;
        end
        if (p_mode == M_STR_HEX) begin
          add_token(K_STR_BYTE, 64'(p_hacc), E_NONE, BASE_DEC);
          p_mode = M_STR;
        end else begin
          p_cval = p_hacc;
          p_mode = M_CHR_CLOSE;
        end
        return !fin && d < NOT_DIGIT;
      end
      M_CHR_OPEN: begin
        if (fin || c == C_NL) begin
          add_error(E_CHR_OPEN);
          return 1'b0;
        end
        advance();
        if (c == C_BSLASH) p_mode = M_CHR_ESC;
        else if (c == C_SQUOTE) add_error(E_CHR_EMPTY);
        else begin
          p_cval = c;
          p_mode = M_CHR_CLOSE;
        end
        return 1'b1;
      end
      M_CHR_CLOSE: begin
        if (!fin && c == C_SQUOTE) begin
          advance();
          add_token(K_CHAR, 64'(p_cval), E_NONE, BASE_DEC);
          p_mode = M_IDLE;
          return 1'b1;
        end
        add_error(E_CHR_OPEN);
        return 1'b0;
      end
      default: begin
        p_mode = M_IDLE;
        lex_idle(c, fin);
        return 1'b1;
      end
    endcase
  endfunction

  // Predicts the tokens that one accepted word completes.
  function automatic void lex_word(src_word_t w);
    token_t t;
    step_tokens.delete();
    for (int i = 0; i < 8; i++) begin
      if (lex_pass(w.ch, w.fin)) break;
    end
    foreach (step_tokens[i]) begin
      t = step_tokens[i];
      t.last = (i == step_tokens.size() - 1);
      expected_tokens = {expected_tokens, t};
    end
  endfunction

  // Stimulus helpers.
  function automatic void put_ch(logic [7:0] c);
    src_word_t w;
    w.fin = 1'b0;
    w.ch = c;
    source_words = {source_words, w};
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_ch(s[i]);
  endfunction

  function automatic void put_end();
    src_word_t w;
    w.fin = 1'b1;
    w.ch = 8'($urandom_range(0, 255));
    source_words = {source_words, w};
  endfunction

  function automatic void put_pick(string set, int n);
    for (int i = 0; i < n; i++) put_ch(set[$urandom_range(0, set.len() - 1)]);
  endfunction

  // A random lexeme, mostly well formed, sometimes followed by a separator.
  function automatic void put_lexeme();
    int sel;
    sel = $urandom_range(0, 19);
    case (sel)
      0, 1: begin
        put_pick("abcxyzABQ_", 1);
        put_pick("az_09QX", $urandom_range(0, 5));
      end
      2, 3: begin
        if ($urandom_range(0, 2) == 0) put_ch(C_MINUS);
        put_pick("123456789", 1);
        put_pick("0123456789", $urandom_range(0, ($urandom_range(0, 5) == 0) ? 20 : 4));
      end
      4: begin
        put_text($urandom_range(0, 1) ? "0x" : "0X");
        put_pick("0123456789abcdefABCDEF", $urandom_range(0, ($urandom_range(0, 3) == 0) ? 17 : 4));
      end
      5: begin
        put_text($urandom_range(0, 1) ? "0b" : "0B");
        put_pick("01", $urandom_range(0, ($urandom_range(0, 3) == 0) ? 66 : 6));
      end
      6: begin
        put_text($urandom_range(0, 1) ? "0o" : "-0O");
        put_pick("01234567", $urandom_range(0, 23));
      end
      7: put_pick("0123456789abxg_Z", $urandom_range(1, 4));
      8, 9: begin
        put_ch(C_SQUOTE);
        case ($urandom_range(0, 3))
          0: put_pick("ntr0\\'\"q", 1);
          1: put_ch(8'($urandom_range(32, 126)));
          2: begin
            put_ch(C_BSLASH);
            put_pick("ntr0\\'\"qx", 1);
          end
          default: begin
            put_text("\\x");
            put_pick("09afAFz", $urandom_range(0, 3));
          end
        endcase
        if ($urandom_range(0, 5) != 0) put_ch(C_SQUOTE);
      end
      10, 11: begin
        put_ch(C_DQUOTE);
        for (int i = $urandom_range(0, 5); i > 0; i--) begin
          if ($urandom_range(0, 3) == 0) begin
            put_ch(C_BSLASH);
            if ($urandom_range(0, 1)) put_pick("ntr0\\'\"q\n", 1);
            else begin
              put_ch(C_LX);
              put_pick("0123456789abcdefFg ", $urandom_range(0, 3));
            end
          end else begin
            put_pick("abc XYZ 129;,#", 1);
          end
        end
        if ($urandom_range(0, 5) != 0) put_ch(C_DQUOTE);
      end
      12, 13: put_pick(":,+-.#[]", 1);
      14: begin
        put_ch(C_SEMI);
        put_pick("ab ;\"'\\-1", $urandom_range(0, 5));
        put_ch(C_NL);
      end
      15: put_ch(8'($urandom_range(0, 255)));
      16: put_end();
      default: put_ch(C_NL);
    endcase
    if ($urandom_range(0, 1)) put_pick(" \t\r\f\v,\n", 1);
  endfunction

  // Source side: bursts of words separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      byte_if.valid <= 1'b0;
    end else begin
      if (byte_if.valid && byte_if.ready) lex_word('{fin: byte_if.end_of_input, ch: byte_if.ch});
      if (!byte_if.valid || byte_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          byte_if.valid <= 1'b0;
        end else if (source_words.size() > 0) begin
          src_word_t w;
          w = source_words.pop_front();
          byte_if.valid <= 1'b1;
          byte_if.ch <= w.ch;
          byte_if.end_of_input <= w.fin;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 10);
            gap_left = $urandom_range(0, 4);
          end
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  end

  // Sink side: ready follows a rotating stall pattern, sometimes all ones.
  logic [7:0] stall_pattern = 8'hFF;
  int         pattern_pos = 0;

  always @(posedge clk) begin
    if (rst) begin
      tok_if.ready <= 1'b0;
    end else begin
      pattern_pos = (pattern_pos + 1) % 64;
      if (pattern_pos == 0) begin
        stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
      end
      tok_if.ready <= stall_pattern[pattern_pos % 8];
    end
  end

  // Token checker.
  always @(posedge clk) begin
    token_t got;
    token_t want;
    if (!rst && tok_if.valid && tok_if.ready) begin
      got = '{kind: tok_if.kind, value: tok_if.value, err: tok_if.error_code,
              base: tok_if.digit_base, line: tok_if.line, column: tok_if.column,
              length: tok_if.length, last: tok_if.last};
      if (expected_tokens.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected token, actual %p", $realtime, got);
      end else begin
        want = expected_tokens.pop_front();
        if (got !== want) begin
          fail_count++;
          $display("%0t: token mismatch, expected %p, actual %p", $realtime, want, got);
        end
      end
    end
  end

  initial begin
    byte_if.valid = 1'b0;
    byte_if.ch = 8'd0;
    byte_if.end_of_input = 1'b0;
    tok_if.ready = 1'b0;
    rst = 1'b1;
    lexer_clear();

    // Directed source text: punctuation, number forms, literals and their errors.
    put_text("l_1: mov r9, #-0x7fffffffffffffff+[0B10].;c\n");
    put_text("9223372036854775808 -9223372036854775808 18446744073709551616 ");
    put_text("0 0x 0b12 0o8 12a - -q 0xFFFFFFFFFFFFFFFFF\n");
    put_text("'a' '\\n' '\\x4' '\\x41z '' 'ab' '\\q' 'x\n");
    put_text("\"s\\x4g\\xZ\\t\\\n\"open\n\"\\x");
    put_end();
    put_text("\"\\");
    put_end();
    put_ch(8'hFF);
    put_ch(8'h80);
    put_ch(8'h00);
    put_text("x\\7");
    put_end();
    put_end();

    while (source_words.size() < 410) put_lexeme();
    put_end();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (source_words.size() != 0 || byte_if.valid);
    do @(posedge clk); while (expected_tokens.size() != 0);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && expected_tokens.size() == 0) begin
      $display("assembly_lexer_stream_test: PASS");
    end else begin
      $display("assembly_lexer_stream_test: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("assembly_lexer_stream_test: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/als_pkg.sv
hdl/als_byte_if.sv
hdl/als_token_if.sv
hdl/assembly_lexer_stream.sv
hdl/als_checker.sv
tb/assembly_lexer_stream_test.sv
